// ===== rtl/irc_pkg.sv =====
// Shared types and constants for the interval relation compare block.
// No dependencies; imported by the top level and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package irc_pkg;

    // Relation of interval A to interval B.
    typedef enum logic [2:0] {
        REL_EQUALS          = 3'd0,
        REL_WITHIN          = 3'd1,
        REL_CONTAINS        = 3'd2,
        REL_OVERLAPS_BEFORE = 3'd3,
        REL_OVERLAPS_AFTER  = 3'd4,
        REL_PRECEDES        = 3'd5,
        REL_PRECEDES_UNION  = 3'd6,
        REL_SUCCEEDS        = 3'd7
    } relation_t;

    localparam int RELATION_BITS = 3;

endpackage

`default_nettype wire

// ===== rtl/interval_relation_compare.sv =====
// Top level of the interval relation compare block: classifies two intervals
// and forms their intersection and hull. Depends on irc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  ----------------------------------------------
// in       in_valid / in_ready   a_start, a_end, a_start_incl, a_end_incl,
//                                b_start, b_end, b_start_incl, b_end_incl
// out      out_valid / out_ready relation, isect_*, hull_*
//
// A transaction accepted on the input passes through the input register and
// then the result register before it shows up on the output. One transaction
// can be accepted every cycle unless the output stalls; the rate is set by
// the single comparator stage between the two registers.
// Reset (rst_n, asynchronous, active low) empties both stages.
// A stalled output holds its result; the input register keeps taking a new
// transaction whenever the result register is free or is being drained.

module interval_relation_compare
    import irc_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input  wire                       clk,
    input  wire                       rst_n,

    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire signed [KEY_BITS-1:0] a_start,
    input  wire signed [KEY_BITS-1:0] a_end,
    input  wire                       a_start_incl,
    input  wire                       a_end_incl,
    input  wire signed [KEY_BITS-1:0] b_start,
    input  wire signed [KEY_BITS-1:0] b_end,
    input  wire                       b_start_incl,
    input  wire                       b_end_incl,

    output logic                      out_valid,
    input  wire                       out_ready,
    output logic [RELATION_BITS-1:0]  relation,
    output logic signed [KEY_BITS-1:0] isect_start,
    output logic signed [KEY_BITS-1:0] isect_end,
    output logic                      isect_start_incl,
    output logic                      isect_end_incl,
    output logic                      isect_empty,
    output logic signed [KEY_BITS-1:0] hull_start,
    output logic signed [KEY_BITS-1:0] hull_end,
    output logic                      hull_start_incl,
    output logic                      hull_end_incl
);

    // Input register stage.
    logic                       s1_valid_reg;
    logic signed [KEY_BITS-1:0] as_reg, ae_reg, bs_reg, be_reg;
    logic                       asi_reg, aei_reg, bsi_reg, bei_reg;

    // Result register stage.
    logic                       out_valid_reg;
    relation_t                  relation_reg;
    logic signed [KEY_BITS-1:0] isect_start_reg, isect_end_reg;
    logic                       isect_start_incl_reg, isect_end_incl_reg, isect_empty_reg;
    logic signed [KEY_BITS-1:0] hull_start_reg, hull_end_reg;
    logic                       hull_start_incl_reg, hull_end_incl_reg;

    // The result register can load when it is empty or being drained this cycle.
    logic s2_ready;
    logic s1_load;
    logic s2_load;

    assign s2_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_valid && in_ready;
    assign s2_load  = s1_valid_reg && s2_ready;

    // Key comparisons, all signed.
    logic as_gt_be, as_eq_be;
    logic bs_gt_ae, bs_eq_ae;
    logic as_lt_bs, as_eq_bs;
    logic ae_gt_be, ae_lt_be, ae_eq_be;

    assign as_gt_be = as_reg > be_reg;
    assign as_eq_be = as_reg == be_reg;
    assign bs_gt_ae = bs_reg > ae_reg;
    assign bs_eq_ae = bs_reg == ae_reg;
    assign as_lt_bs = as_reg < bs_reg;
    assign as_eq_bs = as_reg == bs_reg;
    assign ae_gt_be = ae_reg > be_reg;
    assign ae_lt_be = ae_reg < be_reg;
    assign ae_eq_be = ae_reg == be_reg;

    logic meet, equal, a_inside_b, b_inside_a, a_first, could_union;

    always_comb
    begin
        // The intervals share at least one point; an excluded bound does not
        // touch when the keys tie.
        meet = !(as_gt_be || (as_eq_be && (!asi_reg || !bei_reg)))
            && !(bs_gt_ae || (bs_eq_ae && (!bsi_reg || !aei_reg)));
        equal = (asi_reg == bsi_reg) && (aei_reg == bei_reg) && as_eq_bs && ae_eq_be;
        a_inside_b = !(as_lt_bs || (as_eq_bs && asi_reg && !bsi_reg))
                  && !(ae_gt_be || (ae_eq_be && aei_reg && !bei_reg));
        // B inside A: B starts no earlier than A and ends no later than A.
        b_inside_a = !(!as_lt_bs && !as_eq_bs || (as_eq_bs && bsi_reg && !asi_reg))
                  && !(ae_lt_be || (ae_eq_be && bei_reg && !aei_reg));
        a_first = as_lt_bs || (as_eq_bs && asi_reg && !bsi_reg);
        // Disjoint intervals that touch at one key with one side including it.
        could_union = (aei_reg || bsi_reg) && bs_eq_ae;
    end

    relation_t relation_next;

    always_comb
    begin
        priority if (meet && equal)
            relation_next = REL_EQUALS;
        else if (meet && a_inside_b)
            relation_next = REL_WITHIN;
        else if (meet && b_inside_a)
            relation_next = REL_CONTAINS;
        else if (meet && a_first)
            relation_next = REL_OVERLAPS_BEFORE;
        else if (meet)
            relation_next = REL_OVERLAPS_AFTER;
        else if (a_first && could_union)
            relation_next = REL_PRECEDES_UNION;
        else if (a_first)
            relation_next = REL_PRECEDES;
        else
            relation_next = REL_SUCCEEDS;
    end

    logic signed [KEY_BITS-1:0] isect_start_next, isect_end_next;
    logic                       isect_start_incl_next, isect_end_incl_next, isect_empty_next;
    logic signed [KEY_BITS-1:0] hull_start_next, hull_end_next;
    logic                       hull_start_incl_next, hull_end_incl_next;

    // Intersection bounds. Disjoint relations report an empty, zeroed interval.
    always_comb
    begin
        isect_empty_next = 1'b0;
        unique case (relation_next)
            REL_EQUALS, REL_WITHIN:
            begin
                isect_start_next      = as_reg;
                isect_end_next        = ae_reg;
                isect_start_incl_next = asi_reg;
                isect_end_incl_next   = aei_reg;
            end
            REL_CONTAINS:
            begin
                isect_start_next      = bs_reg;
                isect_end_next        = be_reg;
                isect_start_incl_next = bsi_reg;
                isect_end_incl_next   = bei_reg;
            end
            REL_OVERLAPS_BEFORE:
            begin
                isect_start_next      = bs_reg;
                isect_end_next        = ae_reg;
                isect_start_incl_next = bsi_reg;
                isect_end_incl_next   = aei_reg;
            end
            REL_OVERLAPS_AFTER:
            begin
                isect_start_next      = as_reg;
                isect_end_next        = be_reg;
                isect_start_incl_next = asi_reg;
                isect_end_incl_next   = bei_reg;
            end
            default:
            begin
                isect_start_next      = '0;
                isect_end_next        = '0;
                isect_start_incl_next = 1'b0;
                isect_end_incl_next   = 1'b0;
                isect_empty_next      = 1'b1;
            end
        endcase
    end

    // Hull bounds; the hull spans any gap between the two intervals.
    always_comb
    begin
        unique case (relation_next)
            REL_EQUALS, REL_CONTAINS:
            begin
                hull_start_next      = as_reg;
                hull_end_next        = ae_reg;
                hull_start_incl_next = asi_reg;
                hull_end_incl_next   = aei_reg;
            end
            REL_WITHIN:
            begin
                hull_start_next      = bs_reg;
                hull_end_next        = be_reg;
                hull_start_incl_next = bsi_reg;
                hull_end_incl_next   = bei_reg;
            end
            REL_OVERLAPS_AFTER, REL_SUCCEEDS:
            begin
                hull_start_next      = bs_reg;
                hull_end_next        = ae_reg;
                hull_start_incl_next = bsi_reg;
                hull_end_incl_next   = aei_reg;
            end
            default:
            begin
                hull_start_next      = as_reg;
                hull_end_next        = be_reg;
                hull_start_incl_next = asi_reg;
                hull_end_incl_next   = bei_reg;
            end
        endcase
    end

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            as_reg  <= a_start;
            ae_reg  <= a_end;
            asi_reg <= a_start_incl;
            aei_reg <= a_end_incl;
            bs_reg  <= b_start;
            be_reg  <= b_end;
            bsi_reg <= b_start_incl;
            bei_reg <= b_end_incl;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            relation_reg         <= relation_next;
            isect_start_reg      <= isect_start_next;
            isect_end_reg        <= isect_end_next;
            isect_start_incl_reg <= isect_start_incl_next;
            isect_end_incl_reg   <= isect_end_incl_next;
            isect_empty_reg      <= isect_empty_next;
            hull_start_reg       <= hull_start_next;
            hull_end_reg         <= hull_end_next;
            hull_start_incl_reg  <= hull_start_incl_next;
            hull_end_incl_reg    <= hull_end_incl_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign relation         = relation_reg;
    assign isect_start      = isect_start_reg;
    assign isect_end        = isect_end_reg;
    assign isect_start_incl = isect_start_incl_reg;
    assign isect_end_incl   = isect_end_incl_reg;
    assign isect_empty      = isect_empty_reg;
    assign hull_start       = hull_start_reg;
    assign hull_end         = hull_end_reg;
    assign hull_start_incl  = hull_start_incl_reg;
    assign hull_end_incl    = hull_end_incl_reg;

endmodule

`default_nettype wire

// ===== rtl/irc_checker.sv =====
// Port-level checker for interval_relation_compare, attached by a bind.
// Depends on irc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irc_checker
    import irc_pkg::*;
#(
    parameter int KEY_BITS = 32
)
(
    input wire                       clk,
    input wire                       rst_n,
    input wire                       out_valid,
    input wire                       out_ready,
    input wire [RELATION_BITS-1:0]   relation,
    input wire [KEY_BITS-1:0]        isect_start,
    input wire [KEY_BITS-1:0]        isect_end,
    input wire                       isect_start_incl,
    input wire                       isect_end_incl,
    input wire                       isect_empty,
    input wire [KEY_BITS-1:0]        hull_start,
    input wire [KEY_BITS-1:0]        hull_end,
    input wire                       hull_start_incl,
    input wire                       hull_end_incl
);

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A stalled result holds its relation and intersection.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(relation)
            && $stable(isect_start) && $stable(isect_end) && $stable(isect_empty))
        else $error("stalled result changed");

    // The empty flag goes with exactly the disjoint relations, and zeroes the bounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (isect_empty == (relation == REL_PRECEDES
            || relation == REL_PRECEDES_UNION || relation == REL_SUCCEEDS)))
        else $error("empty flag disagrees with relation");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && isect_empty |-> isect_start == '0 && isect_end == '0
            && !isect_start_incl && !isect_end_incl)
        else $error("empty intersection has nonzero bounds");

    // Equal intervals give an intersection identical to the hull.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && relation == REL_EQUALS |-> isect_start == hull_start
            && isect_end == hull_end && isect_start_incl == hull_start_incl
            && isect_end_incl == hull_end_incl)
        else $error("equal intervals with differing intersection and hull");

endmodule

bind interval_relation_compare irc_checker #(.KEY_BITS(KEY_BITS)) u_irc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .relation         (relation),
    .isect_start      (isect_start),
    .isect_end        (isect_end),
    .isect_start_incl (isect_start_incl),
    .isect_end_incl   (isect_end_incl),
    .isect_empty      (isect_empty),
    .hull_start       (hull_start),
    .hull_end         (hull_end),
    .hull_start_incl  (hull_start_incl),
    .hull_end_incl    (hull_end_incl)
);

`default_nettype wire

// ===== test/interval_relation_compare_tb.sv =====
// Self-checking testbench for interval_relation_compare: directed rows and random
// interval pairs are checked against a predictor built into this file.
// Depends on irc_pkg and the interval_relation_compare top level.
`timescale 1ns / 1ps

module interval_relation_compare_tb;

    import irc_pkg::*;

    localparam int KEY_BITS = 32;
    localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

    // Stimulus size, receiver hold-off, drain time and run limits.
    localparam int RANDOM_PAIRS   = 680;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    // One interval: signed keys at both ends plus an inclusive flag for each end.
    typedef struct {
        logic signed [KEY_BITS-1:0] lo;
        logic signed [KEY_BITS-1:0] hi;
        logic                       lo_incl;
        logic                       hi_incl;
    } interval_t;

    // One input transaction: interval A and interval B.
    typedef struct {
        interval_t a;
        interval_t b;
    } interval_pair_t;

    // One output transaction: relation code, intersection and hull.
    typedef struct {
        relation_t rel;
        interval_t isect;
        logic      isect_empty;
        interval_t hull;
    } relation_result_t;

    // A row of the directed table. When pinned is set, the typed-in expectation
    // is used; otherwise the predictor supplies it.
    typedef struct {
        interval_pair_t   pair;
        bit               pinned;
        relation_result_t want;
    } directed_row_t;

    localparam interval_t NO_INTERVAL = '{0, 0, 1'b0, 1'b0};
    localparam interval_t FULL_RANGE  = '{KEY_MIN, KEY_MAX, 1'b1, 1'b1};
    localparam relation_result_t PREDICTED = '{REL_EQUALS, NO_INTERVAL, 1'b0, NO_INTERVAL};

    localparam int DIRECTED_ROWS = 20;

    // The directed part: extremes of the key range, every relation code, touching
    // bounds with each combination of inclusive flags, inverted intervals and
    // the sign of the key comparison.
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        // Identical full-range intervals.
        '{'{FULL_RANGE, FULL_RANGE}, 1'b1,
          '{REL_EQUALS, FULL_RANGE, 1'b0, FULL_RANGE}},
        // Single points at the two ends of the key range, in both orders.
        '{'{'{KEY_MIN, KEY_MIN, 1'b1, 1'b1}, '{KEY_MAX, KEY_MAX, 1'b1, 1'b1}}, 1'b1,
          '{REL_PRECEDES, NO_INTERVAL, 1'b1, FULL_RANGE}},
        '{'{'{KEY_MAX, KEY_MAX, 1'b1, 1'b1}, '{KEY_MIN, KEY_MIN, 1'b1, 1'b1}}, 1'b1,
          '{REL_SUCCEEDS, NO_INTERVAL, 1'b1, FULL_RANGE}},
        // Minus one must sort below zero.
        '{'{'{-1, -1, 1'b1, 1'b1}, '{0, 0, 1'b1, 1'b1}}, 1'b1,
          '{REL_PRECEDES, NO_INTERVAL, 1'b1, '{-1, 0, 1'b1, 1'b1}}},
        // Open full range inside the closed one.
        '{'{'{KEY_MIN, KEY_MAX, 1'b0, 1'b0}, FULL_RANGE}, 1'b0, PREDICTED},
        '{'{'{0, 10, 1'b1, 1'b1}, '{-5, 20, 1'b1, 1'b1}}, 1'b0, PREDICTED},
        '{'{'{-5, 20, 1'b1, 1'b1}, '{0, 10, 1'b1, 1'b1}}, 1'b0, PREDICTED},
        '{'{'{0, 10, 1'b1, 1'b0}, '{5, 20, 1'b0, 1'b1}}, 1'b0, PREDICTED},
        '{'{'{5, 20, 1'b0, 1'b1}, '{0, 10, 1'b1, 1'b0}}, 1'b0, PREDICTED},
        // Touching at key 5 with only A's end included: could be merged.
        '{'{'{0, 5, 1'b1, 1'b1}, '{5, 10, 1'b0, 1'b1}}, 1'b1,
          '{REL_PRECEDES_UNION, NO_INTERVAL, 1'b1, '{0, 10, 1'b1, 1'b1}}},
        // Touching with only B's start included, with neither, and with both.
        '{'{'{0, 5, 1'b0, 1'b0}, '{5, 10, 1'b1, 1'b0}}, 1'b0, PREDICTED},
        '{'{'{0, 5, 1'b1, 1'b0}, '{5, 10, 1'b0, 1'b1}}, 1'b0, PREDICTED},
        '{'{'{0, 5, 1'b1, 1'b1}, '{5, 10, 1'b1, 1'b1}}, 1'b0, PREDICTED},
        // A starts where B ends, A's start open.
        '{'{'{5, 10, 1'b0, 1'b1}, '{0, 5, 1'b1, 1'b1}}, 1'b0, PREDICTED},
        // Inverted intervals are compared as they are.
        '{'{'{10, 0, 1'b1, 1'b1}, '{0, 10, 1'b1, 1'b1}}, 1'b0, PREDICTED},
        '{'{'{KEY_MAX, KEY_MIN, 1'b0, 1'b1}, '{KEY_MAX, -1, 1'b1, 1'b0}}, 1'b0, PREDICTED},
        // Same keys, flags differ at one end.
        '{'{'{3, 7, 1'b1, 1'b1}, '{3, 7, 1'b1, 1'b0}}, 1'b0, PREDICTED},
        '{'{'{0, 10, 1'b0, 1'b1}, '{0, 10, 1'b1, 1'b1}}, 1'b0, PREDICTED},
        // Open points at the same key, then closed points at the same key.
        '{'{'{0, 0, 1'b0, 1'b0}, '{0, 0, 1'b0, 1'b0}}, 1'b0, PREDICTED},
        '{'{'{0, 0, 1'b1, 1'b1}, '{0, 0, 1'b1, 1'b1}}, 1'b1,
          '{REL_EQUALS, '{0, 0, 1'b1, 1'b1}, 1'b0, '{0, 0, 1'b1, 1'b1}}}
    };

    // Clock, reset and the ports of the block. Reset is driven low at time zero
    // so that the block sees a falling edge; every other input starts known.
    logic clk = 1'b0;
    logic rst_n;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [KEY_BITS-1:0] a_start = '0;
    logic signed [KEY_BITS-1:0] a_end = '0;
    logic                       a_start_incl = 1'b0;
    logic                       a_end_incl = 1'b0;
    logic signed [KEY_BITS-1:0] b_start = '0;
    logic signed [KEY_BITS-1:0] b_end = '0;
    logic                       b_start_incl = 1'b0;
    logic                       b_end_incl = 1'b0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [RELATION_BITS-1:0]   relation;
    logic signed [KEY_BITS-1:0] isect_start;
    logic signed [KEY_BITS-1:0] isect_end;
    logic                       isect_start_incl;
    logic                       isect_end_incl;
    logic                       isect_empty;
    logic signed [KEY_BITS-1:0] hull_start;
    logic signed [KEY_BITS-1:0] hull_end;
    logic                       hull_start_incl;
    logic                       hull_end_incl;

    // Results predicted for accepted transactions, oldest first.
    relation_result_t relation_fifo [$];

    int  sender_idle_pct = 37;
    int  receiver_idle_pct = 88;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  failure_count = 0;
    int  cycle_count = 0;

    interval_relation_compare #(
        .KEY_BITS(KEY_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .a_start(a_start),
        .a_end(a_end),
        .a_start_incl(a_start_incl),
        .a_end_incl(a_end_incl),
        .b_start(b_start),
        .b_end(b_end),
        .b_start_incl(b_start_incl),
        .b_end_incl(b_end_incl),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .relation(relation),
        .isect_start(isect_start),
        .isect_end(isect_end),
        .isect_start_incl(isect_start_incl),
        .isect_end_incl(isect_end_incl),
        .isect_empty(isect_empty),
        .hull_start(hull_start),
        .hull_end(hull_end),
        .hull_start_incl(hull_start_incl),
        .hull_end_incl(hull_end_incl)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // True when x and y share at least one key. At a tie between a start and
    // an end, both bounds must be inclusive for the key to be shared.
    function automatic bit intervals_meet(interval_t x, interval_t y);
        if (x.lo > y.hi || (x.lo == y.hi && !(x.lo_incl && y.hi_incl)))
        begin
            return 1'b0;
        end
        if (y.lo > x.hi || (y.lo == x.hi && !(y.lo_incl && x.hi_incl)))
        begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // True when both keys and both flags of x and y agree.
    function automatic bit same_interval(interval_t x, interval_t y);
        return x.lo == y.lo && x.hi == y.hi
            && x.lo_incl == y.lo_incl && x.hi_incl == y.hi_incl;
    endfunction

    // True when x lies inside y. An included bound of x is outside an
    // excluded bound of y at the same key.
    function automatic bit lies_inside(interval_t x, interval_t y);
        if (x.lo < y.lo || (x.lo == y.lo && x.lo_incl && !y.lo_incl))
        begin
            return 1'b0;
        end
        if (x.hi > y.hi || (x.hi == y.hi && x.hi_incl && !y.hi_incl))
        begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // True when x starts strictly ahead of y; an open start sorts after a
    // closed one at the same key.
    function automatic bit starts_ahead(interval_t x, interval_t y);
        return x.lo < y.lo || (x.lo == y.lo && x.lo_incl && !y.lo_incl);
    endfunction

    function automatic interval_t span(interval_t from_iv, interval_t to_iv);
        interval_t s;
        s.lo      = from_iv.lo;
        s.lo_incl = from_iv.lo_incl;
        s.hi      = to_iv.hi;
        s.hi_incl = to_iv.hi_incl;
        return s;
    endfunction

    // Classifies A against B and forms their intersection and hull.
    function automatic relation_result_t classify_pair(interval_pair_t p);
        relation_result_t r;
        if (intervals_meet(p.a, p.b))
        begin
            if (same_interval(p.a, p.b))
            begin
                r.rel = REL_EQUALS;
            end
            else if (lies_inside(p.a, p.b))
            begin
                r.rel = REL_WITHIN;
            end
            else if (lies_inside(p.b, p.a))
            begin
                r.rel = REL_CONTAINS;
            end
            else if (starts_ahead(p.a, p.b))
            begin
                r.rel = REL_OVERLAPS_BEFORE;
            end
            else
            begin
                r.rel = REL_OVERLAPS_AFTER;
            end
        end
        else if (starts_ahead(p.a, p.b))
        begin
            // A touching pair where one side owns the shared key could be merged.
            if ((p.a.hi_incl || p.b.lo_incl) && p.a.hi == p.b.lo)
            begin
                r.rel = REL_PRECEDES_UNION;
            end
            else
            begin
                r.rel = REL_PRECEDES;
            end
        end
        else
        begin
            r.rel = REL_SUCCEEDS;
        end

        r.isect_empty = 1'b0;
        case (r.rel)
            REL_EQUALS, REL_WITHIN: r.isect = p.a;
            REL_CONTAINS:           r.isect = p.b;
            REL_OVERLAPS_BEFORE:    r.isect = span(p.b, p.a);
            REL_OVERLAPS_AFTER:     r.isect = span(p.a, p.b);
            default:
            begin
                r.isect = NO_INTERVAL;
                r.isect_empty = 1'b1;
            end
        endcase

        case (r.rel)
            REL_EQUALS, REL_CONTAINS:         r.hull = p.a;
            REL_WITHIN:                       r.hull = p.b;
            REL_OVERLAPS_AFTER, REL_SUCCEEDS: r.hull = span(p.b, p.a);
            default:                          r.hull = span(p.a, p.b);
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random interval pairs
    // ------------------------------------------------------------------------

    // Most intervals are well formed; a few are left inverted on purpose.
    function automatic interval_t maybe_ordered(interval_t x);
        logic signed [KEY_BITS-1:0] t;
        if (x.lo > x.hi && $urandom_range(0, 99) < 85)
        begin
            t = x.lo;
            x.lo = x.hi;
            x.hi = t;
        end
        return x;
    endfunction

    // Keys mostly cluster within a few steps of a random base so that ties,
    // touching bounds and overlaps are common. Some pairs use fully random keys,
    // some sit around zero and some at the ends of the key range, where a few wrap.
    task automatic make_random_pair(output interval_pair_t p);
        int                         mode;
        logic signed [KEY_BITS-1:0] base;
        mode = $urandom_range(0, 9);
        base = $urandom;
        if (mode == 1)
        begin
            case ($urandom_range(0, 3))
                0: base = KEY_MIN;
                1: base = KEY_MAX - 8;
                2: base = KEY_MAX - 4;
                default: base = -4;
            endcase
        end
        if (mode == 0)
        begin
            p.a.lo = $urandom;
            p.a.hi = $urandom;
            p.b.lo = $urandom;
            p.b.hi = $urandom;
        end
        else
        begin
            p.a.lo = base + KEY_BITS'($urandom_range(0, 8));
            p.a.hi = base + KEY_BITS'($urandom_range(0, 8));
            p.b.lo = base + KEY_BITS'($urandom_range(0, 8));
            p.b.hi = base + KEY_BITS'($urandom_range(0, 8));
        end
        p.a.lo_incl = 1'($urandom_range(0, 1));
        p.a.hi_incl = 1'($urandom_range(0, 1));
        p.b.lo_incl = 1'($urandom_range(0, 1));
        p.b.hi_incl = 1'($urandom_range(0, 1));
        p.a = maybe_ordered(p.a);
        p.b = maybe_ordered(p.b);
    endtask

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one pair, possibly after some idle cycles, and holds it until the
    // block takes it. The expectation is queued at the accepting edge.
    task automatic offer_pair(input interval_pair_t p, input relation_result_t want);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        a_start      <= p.a.lo;
        a_end        <= p.a.hi;
        a_start_incl <= p.a.lo_incl;
        a_end_incl   <= p.a.hi_incl;
        b_start      <= p.b.lo;
        b_end        <= p.b.hi;
        b_start_incl <= p.b.lo_incl;
        b_end_incl   <= p.b.hi_incl;
        in_valid     <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        relation_fifo.push_back(want);
    endtask

    initial
    begin : stimulus
        interval_pair_t pair;

        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run under the first idling pattern.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_table[i].pinned)
            begin
                offer_pair(directed_table[i].pair, directed_table[i].want);
            end
            else
            begin
                offer_pair(directed_table[i].pair, classify_pair(directed_table[i].pair));
            end
        end

        // Three phases of random pairs: a slow receiver, then a slow sender, then
        // full rate. The third phase opens with a long receiver hold-off while
        // the sender keeps offering, so the pipeline fills and backs up.
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i == RANDOM_PAIRS / 3)
            begin
                sender_idle_pct = 88;
                receiver_idle_pct <= 37;
            end
            else if (i == 2 * RANDOM_PAIRS / 3)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct <= 0;
                hold_request <= 1'b1;
            end
            make_random_pair(pair);
            offer_pair(pair, classify_pair(pair));
        end
        in_valid <= 1'b0;

        while (relation_fifo.size() != 0)
        begin
            @(posedge clk);
        end
        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failure_count == 0)
        begin
            $display("interval_relation_compare_tb OK");
        end
        else
        begin
            $display("interval_relation_compare_tb NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // Ready toggles at random with the current idle percentage. The one long
    // hold-off is counted down here, independent of the sender.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------

    function automatic string describe(relation_result_t r);
        return $sformatf("rel=%0d isect=[%0d,%0d] incl=%b%b empty=%b hull=[%0d,%0d] incl=%b%b",
                         r.rel, r.isect.lo, r.isect.hi, r.isect.lo_incl, r.isect.hi_incl,
                         r.isect_empty, r.hull.lo, r.hull.hi, r.hull.lo_incl, r.hull.hi_incl);
    endfunction

    // Every accepted output transaction is compared field by field with the
    // oldest prediction. Values are sampled at the edge, before any update.
    always @(posedge clk)
    begin : check_results
        relation_result_t want;
        relation_result_t got;
        bit               bad;
        if (out_valid && out_ready)
        begin
            got.rel           = relation_t'(relation);
            got.isect.lo      = isect_start;
            got.isect.hi      = isect_end;
            got.isect.lo_incl = isect_start_incl;
            got.isect.hi_incl = isect_end_incl;
            got.isect_empty   = isect_empty;
            got.hull.lo       = hull_start;
            got.hull.hi       = hull_end;
            got.hull.lo_incl  = hull_start_incl;
            got.hull.hi_incl  = hull_end_incl;
            if (relation_fifo.size() == 0)
            begin
                failure_count++;
                if (failure_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result: %s", describe(got));
                end
            end
            else
            begin
                want = relation_fifo.pop_front();
                bad = (got.rel !== want.rel)
                   || (got.isect.lo !== want.isect.lo)
                   || (got.isect.hi !== want.isect.hi)
                   || (got.isect.lo_incl !== want.isect.lo_incl)
                   || (got.isect.hi_incl !== want.isect.hi_incl)
                   || (got.isect_empty !== want.isect_empty)
                   || (got.hull.lo !== want.hull.lo)
                   || (got.hull.hi !== want.hull.hi)
                   || (got.hull.lo_incl !== want.hull.lo_incl)
                   || (got.hull.hi_incl !== want.hull.hi_incl);
                if (bad)
                begin
                    failure_count++;
                    if (failure_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected %s", describe(want));
                        $display("          actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("interval_relation_compare_tb NOT OK");
            $finish;
        end
    end

endmodule
